[sv/crfrb_pkg.sv]
// Package for the filtered CAN receive ring: field widths, item kinds,
// status codes, CSR indexes and the stored frame record.
// No dependencies; used by every module of the block.
`default_nettype none

package crfrb_pkg;

   // Field widths
   localparam int KIND_W   = 3;
   localparam int ID_W     = 11;
   localparam int DLC_W    = 4;
   localparam int DATA_W   = 64;
   localparam int STATUS_W = 4;
   localparam int RESULT_W = 9;
   localparam int FILL_W   = 4;
   localparam int COUNT_W  = 8;
   localparam int MISM_W   = 3;
   localparam int BYTES    = DATA_W / 8;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_ID   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_WANTED = 2'd1;

   // Ring depth default
   localparam int RING_DEPTH_DEF = 16;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FRAME   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_STARTED  = 4'd0;
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 4'd1;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 4'd2;
   localparam logic [STATUS_W-1:0] ST_DONE     = 4'd3;
   localparam logic [STATUS_W-1:0] ST_ABORTED  = 4'd4;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 4'd5;
   localparam logic [STATUS_W-1:0] ST_POPPED   = 4'd6;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 4'd7;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 4'd8;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 4'd9;

   // Session limits
   localparam logic [MISM_W-1:0] MISMATCH_LIMIT = 3'd5;
   localparam logic [DLC_W-1:0]  MAX_DLC        = 4'd8;

   // One stored frame
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [DLC_W-1:0]  dlc;
      logic [DATA_W-1:0] data;
   } frame_entry_type;

endpackage

`default_nettype wire

[sv/crfrb_ring_mem.sv]
// Frame store of the receive ring: one write port, one registered read port.
// Depends on crfrb_pkg for the frame record type.
`default_nettype none

module crfrb_ring_mem #(
   parameter int RING_DEPTH = crfrb_pkg::RING_DEPTH_DEF,
   parameter int ADDR_W     = $clog2(RING_DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire crfrb_pkg::frame_entry_type  wr_data,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output crfrb_pkg::frame_entry_type       rd_data
);

   crfrb_pkg::frame_entry_type mem [RING_DEPTH];
   crfrb_pkg::frame_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/can_rx_filtered_ring_buffer.sv]
// Top level of the filtered CAN receive ring: session control, ring pointers,
// CSRs and the result register. Depends on crfrb_pkg and crfrb_ring_mem.
//
// The block takes one transaction per clock cycle: busy is low except during
// reset, and the result of a transaction accepted at a clock edge is on the
// rsp_ ports, with rsp_strobe high, for exactly the following cycle. The
// receiver cannot stall; each result must be captured in its strobe cycle.
// Popped frame fields come from the frame store's registered read port,
// which a pop reads at the edge where it is accepted. The ring holds at most
// RING_DEPTH-1 frames; rsp_fill_level carries the low four bits of the count.
// The frame store needs no clearing after reset: only written entries are read.
`default_nettype none

module can_rx_filtered_ring_buffer #(
   parameter int RING_DEPTH = crfrb_pkg::RING_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request side
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [crfrb_pkg::KIND_W-1:0]        req_kind,
   input  wire logic [crfrb_pkg::ID_W-1:0]          req_frame_id,
   input  wire logic [crfrb_pkg::DLC_W-1:0]         req_frame_dlc,
   input  wire logic [crfrb_pkg::DATA_W-1:0]        req_frame_data,
   // response side
   output logic                                     rsp_strobe,
   output logic [crfrb_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [crfrb_pkg::RESULT_W-1:0]    rsp_session_result,
   output logic [crfrb_pkg::FILL_W-1:0]             rsp_fill_level,
   output logic [crfrb_pkg::ID_W-1:0]               rsp_out_id,
   output logic [crfrb_pkg::DLC_W-1:0]              rsp_out_dlc,
   output logic [crfrb_pkg::DATA_W-1:0]             rsp_out_data,
   // CSR write channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [crfrb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [crfrb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(RING_DEPTH);

   // CSRs
   logic [crfrb_pkg::ID_W-1:0]    expected_id_ff;
   logic [crfrb_pkg::COUNT_W-1:0] frames_wanted_ff;

   // Ring and session state
   logic [PTR_W-1:0]               wp_ff, wp_in;
   logic [PTR_W-1:0]               rp_ff, rp_in;
   logic [crfrb_pkg::COUNT_W-1:0]  acc_ff, acc_in;
   logic [crfrb_pkg::MISM_W-1:0]   mism_ff, mism_in;
   logic                           open_ff, open_in;

   // Result register
   logic                                   strobe_ff;
   logic [crfrb_pkg::STATUS_W-1:0]         status_ff, status_in;
   logic signed [crfrb_pkg::RESULT_W-1:0]  result_ff, result_in;
   logic [crfrb_pkg::FILL_W-1:0]           fill_ff, fill_in;

   // Datapath helpers
   logic                           accept;
   logic                           csr_fire;
   logic [PTR_W-1:0]               wp_next;
   logic [PTR_W-1:0]               rp_next;
   logic                           ring_empty;
   logic                           ring_full;
   logic [crfrb_pkg::DLC_W-1:0]    dlc_sat;
   logic [crfrb_pkg::DATA_W-1:0]   data_kept;
   logic [crfrb_pkg::COUNT_W-1:0]  acc_inc;
   logic [crfrb_pkg::MISM_W-1:0]   mism_inc;
   logic [PTR_W:0]                 fill_after;
   logic [PTR_W:0]                 fill_now;
   logic                           mem_wr_en;
   logic                           mem_rd_en;
   crfrb_pkg::frame_entry_type     mem_wr_data;
   crfrb_pkg::frame_entry_type     mem_rd_data;

   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = !reset;
   assign csr_fire  = csr_valid && csr_ready;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff   <= '0;
         frames_wanted_ff <= '0;
      end else if (csr_fire) begin
         unique case (csr_index)
            crfrb_pkg::CSR_EXPECTED_ID:   expected_id_ff   <= csr_wdata;
            crfrb_pkg::CSR_FRAMES_WANTED: frames_wanted_ff <= csr_wdata[crfrb_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Pointer arithmetic
   assign wp_next    = (wp_ff == LAST_IDX) ? '0 : wp_ff + 1'b1;
   assign rp_next    = (rp_ff == LAST_IDX) ? '0 : rp_ff + 1'b1;
   assign ring_empty = (rp_ff == wp_ff);
   assign ring_full  = (wp_next == rp_ff);
   assign acc_inc    = acc_ff + 1'b1;
   assign mism_inc   = mism_ff + 1'b1;

   // Length saturation and payload masking
   assign dlc_sat = (req_frame_dlc > crfrb_pkg::MAX_DLC) ? crfrb_pkg::MAX_DLC : req_frame_dlc;

   always_comb begin
      for (int i = 0; i < crfrb_pkg::BYTES; i++) begin
         data_kept[i*8 +: 8] = (crfrb_pkg::DLC_W'(i) < dlc_sat) ? req_frame_data[i*8 +: 8]
                                                                 : 8'h00;
      end
   end

   assign mem_wr_data.id   = req_frame_id;
   assign mem_wr_data.dlc  = dlc_sat;
   assign mem_wr_data.data = data_kept;

   // Item decode and next state
   always_comb begin
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      acc_in    = acc_ff;
      mism_in   = mism_ff;
      open_in   = open_ff;
      status_in = crfrb_pkg::ST_IGNORED;
      result_in = '0;
      mem_wr_en = 1'b0;
      mem_rd_en = 1'b0;

      if (accept) begin
         unique case (req_kind)
            crfrb_pkg::KIND_START: begin
               acc_in  = '0;
               mism_in = '0;
               if (frames_wanted_ff == '0) begin
                  open_in   = 1'b0;
                  status_in = crfrb_pkg::ST_DONE;
               end else begin
                  open_in   = 1'b1;
                  status_in = crfrb_pkg::ST_STARTED;
               end
            end
            crfrb_pkg::KIND_FRAME: begin
               if (open_ff) begin
                  if (req_frame_id == expected_id_ff) begin
                     if (ring_full) begin
                        status_in = crfrb_pkg::ST_DROPPED;
                     end else begin
                        mem_wr_en = 1'b1;
                        wp_in     = wp_next;
                        acc_in    = acc_inc;
                        if (acc_inc >= frames_wanted_ff) begin
                           open_in   = 1'b0;
                           status_in = crfrb_pkg::ST_DONE;
                           result_in = {1'b0, acc_inc};
                        end else begin
                           status_in = crfrb_pkg::ST_ACCEPTED;
                        end
                     end
                  end else begin
                     mism_in = mism_inc;
                     if (mism_inc > crfrb_pkg::MISMATCH_LIMIT) begin
                        open_in   = 1'b0;
                        status_in = crfrb_pkg::ST_ABORTED;
                        result_in = '1;
                     end else begin
                        status_in = crfrb_pkg::ST_MISMATCH;
                     end
                  end
               end
            end
            crfrb_pkg::KIND_TIMEOUT: begin
               if (open_ff) begin
                  open_in   = 1'b0;
                  status_in = crfrb_pkg::ST_TIMEOUT;
                  result_in = {1'b0, acc_ff};
               end
            end
            crfrb_pkg::KIND_POP: begin
               if (ring_empty) begin
                  status_in = crfrb_pkg::ST_EMPTY;
               end else begin
                  mem_rd_en = 1'b1;
                  rp_in     = rp_next;
                  status_in = crfrb_pkg::ST_POPPED;
               end
            end
            crfrb_pkg::KIND_CLEAR: begin
               wp_in     = '0;
               rp_in     = '0;
               status_in = crfrb_pkg::ST_EMPTY;
            end
            default: ;
         endcase
      end
   end

   // Fill level after the transaction, and as held now
   assign fill_after = (wp_in >= rp_in) ? {1'b0, wp_in} - {1'b0, rp_in}
                                        : {1'b0, wp_in} + DEPTH_X - {1'b0, rp_in};
   assign fill_now   = (wp_ff >= rp_ff) ? {1'b0, wp_ff} - {1'b0, rp_ff}
                                        : {1'b0, wp_ff} + DEPTH_X - {1'b0, rp_ff};

   always_comb begin
      fill_in = '0;
      for (int b = 0; b < crfrb_pkg::FILL_W; b++) begin
         if (b <= PTR_W) begin
            fill_in[b] = fill_after[b];
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         rp_ff     <= '0;
         acc_ff    <= '0;
         mism_ff   <= '0;
         open_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         acc_ff    <= acc_in;
         mism_ff   <= mism_in;
         open_ff   <= open_in;
         strobe_ff <= accept;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         result_ff <= result_in;
         fill_ff   <= fill_in;
      end
   end

   // Frame store
   crfrb_ring_mem #(
      .RING_DEPTH (RING_DEPTH),
      .ADDR_W     (PTR_W)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wp_ff),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rp_ff),
      .rd_data (mem_rd_data)
   );

   // Response ports; frame fields only for a pop that found data
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_session_result = result_ff;
   assign rsp_fill_level     = fill_ff;
   assign rsp_out_id   = (status_ff == crfrb_pkg::ST_POPPED) ? mem_rd_data.id   : '0;
   assign rsp_out_dlc  = (status_ff == crfrb_pkg::ST_POPPED) ? mem_rd_data.dlc  : '0;
   assign rsp_out_data = (status_ff == crfrb_pkg::ST_POPPED) ? mem_rd_data.data : '0;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_now <= DEPTH_X - 1'b1)
      else $error("ring fill above capacity");

   a_mism_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (mism_ff <= crfrb_pkg::MISMATCH_LIMIT))
      else $error("open session past mismatch limit");

   a_pop_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == crfrb_pkg::KIND_POP && !ring_empty)
      |=> (rsp_status == crfrb_pkg::ST_POPPED) && (rp_ff != $past(rp_ff)))
      else $error("pop did not advance read pointer");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == crfrb_pkg::ST_DROPPED) |-> (fill_now == DEPTH_X - 1'b1))
      else $error("frame dropped while ring not full");

   a_close_reason: assert property (@(posedge clock) disable iff (reset)
      ($fell(open_ff) && !$past(reset)) |->
      (rsp_strobe && (rsp_status == crfrb_pkg::ST_DONE || rsp_status == crfrb_pkg::ST_ABORTED
                      || rsp_status == crfrb_pkg::ST_TIMEOUT)))
      else $error("session closed without end status");

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for can_rx_filtered_ring_buffer: directed table, then random
// receive sessions checked against an in-bench model of the session logic and frame ring.
// Depends on crfrb_pkg and the can_rx_filtered_ring_buffer RTL.
module tb;
   import crfrb_pkg::*;

   localparam int RING_N = RING_DEPTH_DEF;
   localparam int PHASE_ITEMS = 250;
   localparam int NUM_PHASES = 7;
   // kinds the block does not define
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RESULT_W-1:0] sess_res;
      logic [FILL_W-1:0]   fill;
      logic [ID_W-1:0]     id;
      logic [DLC_W-1:0]    dlc;
      logic [DATA_W-1:0]   data;
   } rx_result_t;

   typedef struct {
      bit                    cfg_write;
      logic [CSR_IDX_W-1:0]  cfg_idx;
      logic [CSR_DATA_W-1:0] cfg_val;
      logic [KIND_W-1:0]     kind;
      logic [ID_W-1:0]       id;
      logic [DLC_W-1:0]      dlc;
      logic [DATA_W-1:0]     data;
      bit                    typed;
      rx_result_t            want;
   } stim_row_t;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [KIND_W-1:0] req_kind;
   logic [ID_W-1:0] req_frame_id;
   logic [DLC_W-1:0] req_frame_dlc;
   logic [DATA_W-1:0] req_frame_data;
   logic rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic signed [RESULT_W-1:0] rsp_session_result;
   logic [FILL_W-1:0] rsp_fill_level;
   logic [ID_W-1:0] rsp_out_id;
   logic [DLC_W-1:0] rsp_out_dlc;
   logic [DATA_W-1:0] rsp_out_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   can_rx_filtered_ring_buffer i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_frame_id       (req_frame_id),
      .req_frame_dlc      (req_frame_dlc),
      .req_frame_data     (req_frame_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_session_result (rsp_session_result),
      .rsp_fill_level     (rsp_fill_level),
      .rsp_out_id         (rsp_out_id),
      .rsp_out_dlc        (rsp_out_dlc),
      .rsp_out_data       (rsp_out_data),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Model state: ring contents, pointers, session counters, CSRs
   logic [ID_W-1:0]    ring_id   [RING_N];
   logic [DLC_W-1:0]   ring_dlc  [RING_N];
   logic [DATA_W-1:0]  ring_data [RING_N];
   int                 wr_ptr = 0;
   int                 rd_ptr = 0;
   logic [COUNT_W-1:0] acc_cnt = '0;
   int                 mism_cnt = 0;
   bit                 sess_open = 1'b0;
   logic [ID_W-1:0]    cfg_exp_id = '0;
   logic [COUNT_W-1:0] cfg_wanted = '0;

   rx_result_t frame_results_due[$];
   int         err_cnt = 0;
   int         active_items = 0;
   bit         row_typed = 1'b0;
   rx_result_t row_want = '0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Safety net against a hung handshake
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Apply one transaction to the model state; returns the expected result
   function automatic rx_result_t ring_predict(logic [KIND_W-1:0] kind, logic [ID_W-1:0] fid,
                                               logic [DLC_W-1:0] fdlc, logic [DATA_W-1:0] fdata);
      rx_result_t r;
      int nxt;
      logic [DLC_W-1:0] len;
      r = '0;
      r.status = ST_IGNORED;
      case (kind)
         KIND_START: begin
            acc_cnt = '0;
            mism_cnt = 0;
            sess_open = (cfg_wanted != 0);
            r.status = sess_open ? ST_STARTED : ST_DONE;
         end
         KIND_FRAME: begin
            if (sess_open && fid == cfg_exp_id) begin
               nxt = (wr_ptr + 1) % RING_N;
               if (nxt == rd_ptr) begin
                  r.status = ST_DROPPED;
               end else begin
                  len = (fdlc > MAX_DLC) ? MAX_DLC : fdlc;
                  ring_id[wr_ptr] = fid;
                  ring_dlc[wr_ptr] = len;
                  // bytes at or past the length are stored as zero
                  ring_data[wr_ptr] = (len >= MAX_DLC) ? fdata
                                      : fdata & ((64'd1 << (8 * len)) - 64'd1);
                  wr_ptr = nxt;
                  acc_cnt = acc_cnt + 1'b1;
                  if (acc_cnt >= cfg_wanted) begin
                     sess_open = 1'b0;
                     r.status = ST_DONE;
                     r.sess_res = {1'b0, acc_cnt};
                  end else begin
                     r.status = ST_ACCEPTED;
                  end
               end
            end else if (sess_open) begin
               mism_cnt++;
               if (mism_cnt > MISMATCH_LIMIT) begin
                  sess_open = 1'b0;
                  r.status = ST_ABORTED;
                  r.sess_res = '1;
               end else begin
                  r.status = ST_MISMATCH;
               end
            end
         end
         KIND_TIMEOUT: begin
            if (sess_open) begin
               sess_open = 1'b0;
               r.status = ST_TIMEOUT;
               r.sess_res = {1'b0, acc_cnt};
            end
         end
         KIND_POP: begin
            if (rd_ptr == wr_ptr) begin
               r.status = ST_EMPTY;
            end else begin
               r.id = ring_id[rd_ptr];
               r.dlc = ring_dlc[rd_ptr];
               r.data = ring_data[rd_ptr];
               rd_ptr = (rd_ptr + 1) % RING_N;
               r.status = ST_POPPED;
            end
         end
         KIND_CLEAR: begin
            wr_ptr = 0;
            rd_ptr = 0;
            r.status = ST_EMPTY;
         end
         default: ;
      endcase
      r.fill = FILL_W'((wr_ptr + RING_N - rd_ptr) % RING_N);
      return r;
   endfunction

   function automatic void flag_error(string msg);
      err_cnt++;
      if (err_cnt <= 10)
         $display("%s", msg);
   endfunction

   // Scoreboard: check results, track CSR writes, predict accepted transactions
   always @(posedge clock) begin : scoreboard_p
      rx_result_t got;
      rx_result_t want;
      if (!reset) begin
         if (rsp_strobe) begin
            got = {rsp_status, rsp_session_result, rsp_fill_level,
                   rsp_out_id, rsp_out_dlc, rsp_out_data};
            if (frame_results_due.size() == 0) begin
               flag_error($sformatf("unexpected result st=%0d res=%0d fill=%0d",
                                    got.status, $signed(got.sess_res), got.fill));
            end else begin
               want = frame_results_due.pop_front();
               if (got !== want)
                  flag_error($sformatf({"result mismatch: want st=%0d res=%0d fill=%0d ",
                                        "id=%h dlc=%0d data=%h / got st=%0d res=%0d ",
                                        "fill=%0d id=%h dlc=%0d data=%h"},
                                       want.status, $signed(want.sess_res), want.fill,
                                       want.id, want.dlc, want.data,
                                       got.status, $signed(got.sess_res), got.fill,
                                       got.id, got.dlc, got.data));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EXPECTED_ID:   cfg_exp_id = csr_wdata[ID_W-1:0];
               CSR_FRAMES_WANTED: cfg_wanted = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            want = ring_predict(req_kind, req_frame_id, req_frame_dlc, req_frame_data);
            if (want.status != ST_IGNORED)
               active_items++;
            frame_results_due.push_back(row_typed ? row_want : want);
         end
      end
   end

   // Table row builders
   function automatic rx_result_t mk_res(logic [STATUS_W-1:0] st, logic [RESULT_W-1:0] res,
                                         logic [FILL_W-1:0] fill, logic [ID_W-1:0] oid,
                                         logic [DLC_W-1:0] odlc, logic [DATA_W-1:0] odata);
      return {st, res, fill, oid, odlc, odata};
   endfunction

   function automatic stim_row_t row_do(logic [KIND_W-1:0] kind, logic [ID_W-1:0] fid,
                                        logic [DLC_W-1:0] fdlc, logic [DATA_W-1:0] fdata);
      stim_row_t r;
      r = '{default: '0};
      r.kind = kind;
      r.id = fid;
      r.dlc = fdlc;
      r.data = fdata;
      return r;
   endfunction

   function automatic stim_row_t row_chk(logic [KIND_W-1:0] kind, logic [ID_W-1:0] fid,
                                         logic [DLC_W-1:0] fdlc, logic [DATA_W-1:0] fdata,
                                         rx_result_t want);
      stim_row_t r;
      r = row_do(kind, fid, fdlc, fdata);
      r.typed = 1'b1;
      r.want = want;
      return r;
   endfunction

   function automatic stim_row_t row_cfg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      stim_row_t r;
      r = '{default: '0};
      r.cfg_write = 1'b1;
      r.cfg_idx = idx;
      r.cfg_val = val;
      return r;
   endfunction

   // Driver tasks; each is entered and left at a falling edge
   task automatic drive_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] fid,
                             input logic [DLC_W-1:0] fdlc, input logic [DATA_W-1:0] fdata,
                             input bit typed, input rx_result_t want);
      start <= 1'b1;
      req_kind <= kind;
      req_frame_id <= fid;
      req_frame_dlc <= fdlc;
      req_frame_data <= fdata;
      row_typed = typed;
      row_want = want;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int cycles);
      start <= 1'b0;
      req_kind <= KIND_W'($urandom);
      req_frame_id <= ID_W'($urandom);
      req_frame_dlc <= DLC_W'($urandom);
      req_frame_data <= {$urandom, $urandom};
      repeat (cycles) @(negedge clock);
   endtask

   // Block goes quiet: no transaction in flight, every result seen
   task automatic wait_drained();
      start <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Random transaction, mostly well-formed session traffic
   task automatic pick_random(output logic [KIND_W-1:0] kind, output logic [ID_W-1:0] fid,
                              output logic [DLC_W-1:0] fdlc, output logic [DATA_W-1:0] fdata);
      int roll;
      roll = $urandom_range(0, 99);
      fid = ID_W'($urandom);
      fdlc = DLC_W'(($urandom_range(0, 3) == 0) ? $urandom_range(9, 15)
                                                : $urandom_range(0, 8));
      fdata = {$urandom, $urandom};
      kind = KIND_W'($urandom_range(0, 7));
      if (!sess_open) begin
         if (roll < 55)
            kind = KIND_START;
         else if (roll < 75)
            kind = KIND_POP;
         else if (roll < 80)
            kind = KIND_CLEAR;
      end else begin
         if (roll < 55) begin
            kind = KIND_FRAME;
            fid = cfg_exp_id;
         end else if (roll < 65)
            kind = KIND_FRAME;
         else if (roll < 82)
            kind = KIND_POP;
         else if (roll < 85)
            kind = KIND_TIMEOUT;
         else if (roll < 87)
            kind = KIND_CLEAR;
         else if (roll < 90)
            kind = KIND_START;
      end
   endtask

   // Main sequence
   initial begin : main_p
      stim_row_t dir_tab[$];
      stim_row_t row;
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0] fid;
      logic [DLC_W-1:0] fdlc;
      logic [DATA_W-1:0] fdata;
      logic [ID_W-1:0] ph_id;
      logic [COUNT_W-1:0] ph_wanted;
      int idle_pct;
      int target;

      reset <= 1'b1;
      start <= 1'b0;
      req_kind <= KIND_START;
      req_frame_id <= '0;
      req_frame_dlc <= '0;
      req_frame_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_EXPECTED_ID;
      csr_wdata <= '0;

      // Directed table; reset config is expected_id 0, frames_wanted 0
      dir_tab.push_back(row_chk(KIND_POP, '0, '0, '0, mk_res(ST_EMPTY, '0, '0, '0, '0, '0)));
      dir_tab.push_back(row_chk(KIND_FRAME, '0, 4'd8, '0,
                                mk_res(ST_IGNORED, '0, '0, '0, '0, '0)));
      dir_tab.push_back(row_chk(KIND_TIMEOUT, '0, '0, '0,
                                mk_res(ST_IGNORED, '0, '0, '0, '0, '0)));
      dir_tab.push_back(row_chk(KIND_START, '0, '0, '0, mk_res(ST_DONE, '0, '0, '0, '0, '0)));
      dir_tab.push_back(row_chk(KIND_SPARE_LO, '1, '1, '1,
                                mk_res(ST_IGNORED, '0, '0, '0, '0, '0)));
      dir_tab.push_back(row_chk(KIND_SPARE_HI, '0, '0, '0,
                                mk_res(ST_IGNORED, '0, '0, '0, '0, '0)));
      dir_tab.push_back(row_cfg(CSR_EXPECTED_ID, 11'h7FF));
      dir_tab.push_back(row_cfg(CSR_FRAMES_WANTED, 11'h7FF));
      dir_tab.push_back(row_chk(KIND_START, '0, '0, '0, mk_res(ST_STARTED, '0, '0, '0, '0, '0)));
      // length above eight saturates; zero length clears the payload
      dir_tab.push_back(row_chk(KIND_FRAME, '1, '1, '1,
                                mk_res(ST_ACCEPTED, '0, 4'd1, '0, '0, '0)));
      dir_tab.push_back(row_chk(KIND_FRAME, '1, '0, '1,
                                mk_res(ST_ACCEPTED, '0, 4'd2, '0, '0, '0)));
      dir_tab.push_back(row_do(KIND_FRAME, '1, 4'd3, 64'h0123_4567_89AB_CDEF));
      // five mismatches are tolerated, the sixth aborts
      repeat (5)
         dir_tab.push_back(row_chk(KIND_FRAME, '0, 4'd8, '1,
                                   mk_res(ST_MISMATCH, '0, 4'd3, '0, '0, '0)));
      dir_tab.push_back(row_chk(KIND_FRAME, '0, 4'd8, '1,
                                mk_res(ST_ABORTED, '1, 4'd3, '0, '0, '0)));
      dir_tab.push_back(row_chk(KIND_POP, '0, '0, '0,
                                mk_res(ST_POPPED, '0, 4'd2, '1, 4'd8, '1)));
      dir_tab.push_back(row_chk(KIND_POP, '0, '0, '0,
                                mk_res(ST_POPPED, '0, 4'd1, '1, '0, '0)));
      dir_tab.push_back(row_do(KIND_START, '0, '0, '0));
      dir_tab.push_back(row_do(KIND_FRAME, '1, 4'd8, 64'hA5A5_5A5A_F00F_0FF0));
      // restart while open zeroes the count
      dir_tab.push_back(row_chk(KIND_START, '0, '0, '0,
                                mk_res(ST_STARTED, '0, 4'd2, '0, '0, '0)));
      dir_tab.push_back(row_chk(KIND_TIMEOUT, '0, '0, '0,
                                mk_res(ST_TIMEOUT, '0, 4'd2, '0, '0, '0)));
      dir_tab.push_back(row_chk(KIND_CLEAR, '0, '0, '0, mk_res(ST_EMPTY, '0, '0, '0, '0, '0)));
      dir_tab.push_back(row_chk(KIND_POP, '0, '0, '0, mk_res(ST_EMPTY, '0, '0, '0, '0, '0)));
      dir_tab.push_back(row_cfg(CSR_FRAMES_WANTED, 11'd1));
      dir_tab.push_back(row_do(KIND_START, '0, '0, '0));
      dir_tab.push_back(row_chk(KIND_FRAME, '1, 4'd5, '1,
                                mk_res(ST_DONE, 9'd1, 4'd1, '0, '0, '0)));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_tab[n]) begin
         row = dir_tab[n];
         if (row.cfg_write) begin
            wait_drained();
            csr_write(row.cfg_idx, row.cfg_val);
         end else begin
            drive_item(row.kind, row.id, row.dlc, row.data, row.typed, row.want);
         end
      end

      // Random phases, each with its own configuration and one of three idle rates
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 79 : 6;
         ph_id = ID_W'($urandom);
         ph_wanted = COUNT_W'($urandom_range(2, 20));
         case (ph)
            0: begin ph_id = '0; ph_wanted = 8'd1; end
            1: begin ph_id = '1; ph_wanted = '1; end
            3: ph_wanted = '0;
            5: ph_wanted = 8'd15;
            default: ;
         endcase
         wait_drained();
         csr_write(CSR_EXPECTED_ID, ph_id);
         csr_write(CSR_FRAMES_WANTED, {3'($urandom), ph_wanted});
         // spare register indexes must have no effect
         csr_write(CSR_IDX_W'($urandom_range(2, 3)), CSR_DATA_W'($urandom));
         target = active_items + PHASE_ITEMS;
         while (active_items < target) begin
            pick_random(kind, fid, fdlc, fdata);
            drive_item(kind, fid, fdlc, fdata, 1'b0, '0);
            // each cycle is idle with probability idle_pct percent
            while ($urandom_range(0, 99) < idle_pct)
               idle_gap(1);
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (err_cnt == 0 && frame_results_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[can_rx_filtered_ring_buffer.f]
sv/crfrb_pkg.sv
sv/crfrb_ring_mem.sv
sv/can_rx_filtered_ring_buffer.sv
dv/tb.sv
